/* sv/sct_pkg.sv */
// Shared types and constants of the sine/cosine Taylor unit.
package sct_pkg;

	// 256 / (2*pi) rounded up, scaled by 2^-32: estimates the period count of a Q8.24 angle.
	localparam logic signed [7:0] RECIP_TWO_PI = 8'sd41;

	// Angle constants in Q.52.
	localparam logic [54:0] TWO_PI        = 55'h6487ED5110B461;
	localparam logic [54:0] PI            = 55'h3243F6A8885A31;
	localparam logic [54:0] HALF_PI       = 55'h1921FB54442D18;
	localparam logic [54:0] THREE_HALF_PI = 55'h4B65F1FCCC8749;

	// Taylor coefficients in unsigned Q.31.
	localparam logic [31:0] Q31_ONE       = 32'd2147483648;
	localparam logic [31:0] Q31_INV2      = 32'd1073741824;
	localparam logic [31:0] Q31_INV24     = 32'd89478485;
	localparam logic [31:0] Q31_INV720    = 32'd2982616;
	localparam logic [31:0] Q31_INV40320  = 32'd53261;
	localparam logic [31:0] Q31_INV6      = 32'd357913941;
	localparam logic [31:0] Q31_INV120    = 32'd17895697;
	localparam logic [31:0] Q31_INV5040   = 32'd426088;
	localparam logic [31:0] Q31_INV362880 = 32'd5918;

	typedef struct packed {
		logic        valid;
		logic        kind;
		logic        neg;
		logic [31:0] u;
	} red_t;

	typedef struct packed {
		logic        valid;
		logic        neg;
		logic [32:0] h;
	} pol_t;

endpackage

/* sv/sct_reduce.sv */
// Range reduction: angle modulo 2*pi, quadrant fold and rounding to unsigned Q.31.
module sct_reduce (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_kind,
	input  logic signed [31:0]  in_angle,
	output sct_pkg::red_t       red
);

	typedef enum logic [1:0] {QUAD0, QUAD1, QUAD2, QUAD3} quad_t;

	logic                v_s1, v_s2, v_s3, v_s4, v_s5;
	logic                kind_s1, kind_s2, kind_s3, kind_s4, kind_s5;
	logic                neg_s5;
	logic signed [31:0]  angle_s1;
	logic signed [5:0]   q_s1;
	logic signed [56:0]  rp_s2;
	logic [54:0]         r_s3;
	logic [52:0]         f_s4;
	quad_t               quad_s4;
	logic [31:0]         u_s5;

	logic signed [37:0]  prod;
	logic signed [61:0]  x_ext;
	logic signed [61:0]  q_tp;
	logic signed [61:0]  rp;
	logic signed [56:0]  tp_ext;
	logic signed [56:0]  r_fix;
	logic [54:0]         f_full;
	quad_t               quad;
	logic [52:0]         f_rnd;
	logic                neg;

	always_comb begin
		prod   = 38'(in_angle) * 38'(sct_pkg::RECIP_TWO_PI);
		x_ext  = 62'($signed({angle_s1, 28'd0}));
		q_tp   = 62'(q_s1) * 62'($signed({1'b0, sct_pkg::TWO_PI}));
		rp     = x_ext - q_tp;
		tp_ext = 57'($signed({1'b0, sct_pkg::TWO_PI}));
		if (rp_s2 < 0) begin
			r_fix = rp_s2 + tp_ext;
		end else if (rp_s2 >= tp_ext) begin
			r_fix = rp_s2 - tp_ext;
		end else begin
			r_fix = rp_s2;
		end
		if (r_s3 < sct_pkg::HALF_PI) begin
			quad   = QUAD0;
			f_full = r_s3;
		end else if (r_s3 < sct_pkg::PI) begin
			quad   = QUAD1;
			f_full = sct_pkg::PI - r_s3;
		end else if (r_s3 < sct_pkg::THREE_HALF_PI) begin
			quad   = QUAD2;
			f_full = r_s3 - sct_pkg::PI;
		end else begin
			quad   = QUAD3;
			f_full = sct_pkg::TWO_PI - r_s3;
		end
		f_rnd = f_s4 + 53'd1048576;
		case (quad_s4)
			QUAD0:   neg = 1'b0;
			QUAD1:   neg = !kind_s4;
			QUAD2:   neg = 1'b1;
			QUAD3:   neg = kind_s4;
			default: neg = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1  <= in_kind;
		angle_s1 <= in_angle;
		q_s1     <= prod[37:32];
		kind_s2  <= kind_s1;
		rp_s2    <= rp[56:0];
		kind_s3  <= kind_s2;
		r_s3     <= r_fix[54:0];
		kind_s4  <= kind_s3;
		quad_s4  <= quad;
		f_s4     <= f_full[52:0];
		kind_s5  <= kind_s4;
		neg_s5   <= neg;
		u_s5     <= f_rnd[52:21];
	end

	assign red = '{valid: v_s5, kind: kind_s5, neg: neg_s5, u: u_s5};

endmodule

/* sv/sct_poly.sv */
// Taylor polynomial by Horner's rule: one multiply per stage, with a saturating subtract in each Horner step.
module sct_poly (
	input  logic          clk,
	input  logic          arst_n,
	input  sct_pkg::red_t red,
	output sct_pkg::pol_t pol
);

	logic        v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic        kind_s1, kind_s2, kind_s3, kind_s4, kind_s5;
	logic        neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;
	logic [31:0] u_s1, u_s2, u_s3, u_s4, u_s5;
	logic [32:0] x2_s1, x2_s2, x2_s3, x2_s4;
	logic [31:0] h_s2, h_s3, h_s4, h_s5;
	logic [32:0] h_s6;

	logic [33:0] x2_full;
	logic [31:0] h1, h2, h3, h4;
	logic [33:0] hu;

	function automatic logic [33:0] qmul(input logic [32:0] a, input logic [31:0] b);
		logic [64:0] p;
		p = 65'(a) * 65'(b) + (65'd1 << 30);
		return p[64:31];
	endfunction

	function automatic logic [31:0] qsub(input logic [31:0] a, input logic [33:0] b);
		if (34'(a) > b) begin
			return a - b[31:0];
		end
		return 32'd0;
	endfunction

	always_comb begin
		x2_full = qmul(33'(red.u), red.u);
		h1 = qsub(kind_s1 ? sct_pkg::Q31_INV5040 : sct_pkg::Q31_INV720,
			qmul(x2_s1, kind_s1 ? sct_pkg::Q31_INV362880 : sct_pkg::Q31_INV40320));
		h2 = qsub(kind_s2 ? sct_pkg::Q31_INV120 : sct_pkg::Q31_INV24, qmul(x2_s2, h_s2));
		h3 = qsub(kind_s3 ? sct_pkg::Q31_INV6 : sct_pkg::Q31_INV2, qmul(x2_s3, h_s3));
		h4 = qsub(sct_pkg::Q31_ONE, qmul(x2_s4, h_s4));
		hu = qmul(33'(u_s5), h_s5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= red.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= red.kind;
		neg_s1  <= red.neg;
		u_s1    <= red.u;
		x2_s1   <= x2_full[32:0];
		kind_s2 <= kind_s1;
		neg_s2  <= neg_s1;
		u_s2    <= u_s1;
		x2_s2   <= x2_s1;
		h_s2    <= h1;
		kind_s3 <= kind_s2;
		neg_s3  <= neg_s2;
		u_s3    <= u_s2;
		x2_s3   <= x2_s2;
		h_s3    <= h2;
		kind_s4 <= kind_s3;
		neg_s4  <= neg_s3;
		u_s4    <= u_s3;
		x2_s4   <= x2_s3;
		h_s4    <= h3;
		kind_s5 <= kind_s4;
		neg_s5  <= neg_s4;
		u_s5    <= u_s4;
		h_s5    <= h4;
		neg_s6  <= neg_s5;
		h_s6    <= kind_s5 ? hu[32:0] : 33'(h_s5);
	end

	assign pol = '{valid: v_s6, neg: neg_s6, h: h_s6};

endmodule

/* sv/sin_cos_taylor_approx.sv */
// Top level of the pipelined sine/cosine unit with its output register.
//
// The unit takes one beat on every clock cycle: busy is never raised, so an
// item is taken whenever start is high. Each item gives one result beat, marked
// by done for one cycle; five stages reduce and fold the angle, six evaluate
// the polynomial with one multiplier each, and the last applies rounding and
// sign. Results leave in the order the items came in, and the receiver must
// take each one in the cycle it appears.
module sin_cos_taylor_approx (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               kind,
	input  logic signed [31:0] angle,
	output logic               done,
	output logic signed [31:0] value
);

	localparam int LATENCY = 12;

	sct_pkg::red_t      red;
	sct_pkg::pol_t      pol;
	logic [33:0]        h_rnd;
	logic [31:0]        mag;
	logic               done_q;
	logic signed [31:0] value_q;

	assign busy = 1'b0;

	sct_reduce u_reduce (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.in_kind  (kind),
		.in_angle (angle),
		.red      (red)
	);

	sct_poly u_poly (
		.clk    (clk),
		.arst_n (arst_n),
		.red    (red),
		.pol    (pol)
	);

	always_comb begin
		h_rnd = 34'(pol.h) + 34'd1;
		mag   = h_rnd[32:1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= pol.valid;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= pol.neg ? -$signed(mag) : $signed(mag);
	end

	assign done  = done_q;
	assign value = value_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("accepted beat did not produce a result after the pipeline latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result beat without a matching accepted beat");

endmodule

/* tb/tb_sin_cos_taylor_approx.sv */
// Self-checking testbench of the pipelined sine/cosine Taylor unit.
`timescale 1ns / 100ps

module tb_sin_cos_taylor_approx;

	localparam logic KIND_COS = 1'b0;
	localparam logic KIND_SIN = 1'b1;
	localparam int   RANDOM_ITEMS = 1150;
	localparam int   CALM_TAIL = 150;
	localparam int   CYCLE_LIMIT = 200000;
	localparam int   Q824_TWO_PI = 105414357;
	localparam int   Q824_HALF_PI = 26353589;

	typedef struct packed {
		logic        kind;
		logic [31:0] angle;
		logic        drain;
	} angle_beat_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] angle;
		logic [31:0] value;
	} sincos_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               kind;
	logic signed [31:0] angle;
	logic               done;
	logic signed [31:0] value;

	angle_beat_t angle_queue[$];
	sincos_t     sincos_queue[$];
	int          errors = 0;
	int          cycles = 0;
	int          gap_left = 0;
	int          accepted = 0;
	int          checked = 0;
	bit          bursty = 1'b1;

	sin_cos_taylor_approx dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.kind   (kind),
		.angle  (angle),
		.done   (done),
		.value  (value)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic logic [63:0] mul_q31(input logic [63:0] a, input logic [63:0] b);
		return (a * b + (64'd1 << 30)) >> 31;
	endfunction

	function automatic logic [63:0] sub_floor(input logic [63:0] a, input logic [63:0] b);
		return (a > b) ? a - b : 64'd0;
	endfunction

	function automatic logic [31:0] taylor_sin_cos(input logic sel, input logic [31:0] ang);
		longint      tp;
		longint      x;
		longint      r;
		logic [63:0] ur;
		logic [63:0] f;
		logic [63:0] u;
		logic [63:0] x2;
		logic [63:0] h;
		logic [63:0] mag;
		logic        neg;
		tp = longint'(sct_pkg::TWO_PI);
		x = longint'($signed(ang)) * 64'sd268435456;
		r = x % tp;
		if (r < 0)
			r = r + tp;
		ur = 64'(r);
		if (ur < 64'(sct_pkg::HALF_PI)) begin
			f = ur;
			neg = 1'b0;
		end else if (ur < 64'(sct_pkg::PI)) begin
			f = 64'(sct_pkg::PI) - ur;
			neg = (sel == KIND_COS);
		end else if (ur < 64'(sct_pkg::THREE_HALF_PI)) begin
			f = ur - 64'(sct_pkg::PI);
			neg = 1'b1;
		end else begin
			f = 64'(sct_pkg::TWO_PI) - ur;
			neg = (sel == KIND_SIN);
		end
		u = (f + (64'd1 << 20)) >> 21;
		x2 = mul_q31(u, u);
		if (sel == KIND_SIN) begin
			h = sub_floor(64'(sct_pkg::Q31_INV5040), mul_q31(x2, 64'(sct_pkg::Q31_INV362880)));
			h = sub_floor(64'(sct_pkg::Q31_INV120), mul_q31(x2, h));
			h = sub_floor(64'(sct_pkg::Q31_INV6), mul_q31(x2, h));
			h = sub_floor(64'(sct_pkg::Q31_ONE), mul_q31(x2, h));
			h = mul_q31(u, h);
		end else begin
			h = sub_floor(64'(sct_pkg::Q31_INV720), mul_q31(x2, 64'(sct_pkg::Q31_INV40320)));
			h = sub_floor(64'(sct_pkg::Q31_INV24), mul_q31(x2, h));
			h = sub_floor(64'(sct_pkg::Q31_INV2), mul_q31(x2, h));
			h = sub_floor(64'(sct_pkg::Q31_ONE), mul_q31(x2, h));
		end
		mag = (h + 64'd1) >> 1;
		if (neg)
			mag = 64'd0 - mag;
		return mag[31:0];
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t: %s", $time, what);
		errors++;
	endtask

	task automatic queue_angle(input logic sel, input logic [31:0] ang, input logic drain);
		angle_beat_t b;
		b.kind = sel;
		b.angle = ang;
		b.drain = drain;
		angle_queue.push_back(b);
	endtask

	// Driver: takes beats from the queue, with random gaps and an occasional drain.
	always @(posedge clk or negedge arst_n) begin : drive
		angle_beat_t nxt;
		sincos_t     exp_item;
		logic        go;
		if (!arst_n) begin
			start <= 1'b0;
			kind <= KIND_COS;
			angle <= '0;
			gap_left = 0;
		end else begin
			if (start && !busy) begin
				exp_item.kind = kind;
				exp_item.angle = angle;
				exp_item.value = taylor_sin_cos(kind, angle);
				sincos_queue.push_back(exp_item);
				accepted++;
				if (accepted % 64 == 0)
					bursty = ($urandom_range(0, 2) != 0);
			end
			if (!(start && busy)) begin
				go = 1'b0;
				if (gap_left != 0) begin
					gap_left--;
				end else if (angle_queue.size() != 0) begin
					if (!(angle_queue[0].drain && (accepted - checked) > (done ? 1 : 0))) begin
						nxt = angle_queue.pop_front();
						go = 1'b1;
						kind <= nxt.kind;
						angle <= nxt.angle;
						if (bursty && angle_queue.size() > CALM_TAIL &&
						    $urandom_range(0, 5) == 0)
							gap_left = $urandom_range(1, 14);
					end
				end
				start <= go;
			end
		end
	end

	// Monitor: every result beat is checked against the oldest prediction.
	always @(posedge clk) begin : watch
		sincos_t exp_item;
		if (arst_n && done) begin
			checked <= checked + 1;
			if (sincos_queue.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", value));
			end else begin
				exp_item = sincos_queue.pop_front();
				if (value !== exp_item.value)
					report_mismatch($sformatf("kind %0b angle %h: value %h, predicted %h",
						exp_item.kind, exp_item.angle, value, exp_item.value));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("sin_cos_taylor_approx verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		int          edges[12];
		int          k;
		logic [31:0] ang;
		logic        sel;
		int          mode;
		edges = '{0, 32'h7FFFFFFF, 32'h80000000, -1, 1, Q824_TWO_PI, Q824_TWO_PI + 1,
			-Q824_TWO_PI, Q824_HALF_PI, Q824_HALF_PI + 1, 2 * Q824_HALF_PI + 1,
			3 * Q824_HALF_PI + 1};
		foreach (edges[i]) begin
			queue_angle(KIND_COS, edges[i], 1'b0);
			queue_angle(KIND_SIN, edges[i], 1'b0);
		end
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			sel = 1'($urandom_range(0, 1));
			mode = $urandom_range(0, 2);
			if (mode == 0) begin
				ang = $urandom;
			end else if (mode == 1) begin
				ang = int'($urandom_range(0, 8 * Q824_TWO_PI)) - 4 * Q824_TWO_PI;
			end else begin
				k = int'($urandom_range(0, 162)) - 81;
				ang = k * Q824_HALF_PI + int'($urandom_range(0, 128)) - 64;
			end
			queue_angle(sel, ang,
				n == 0 || (n < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 79) == 0));
		end
		@(posedge arst_n);
		do
			@(negedge clk);
		while (angle_queue.size() != 0 || start || sincos_queue.size() != 0);
		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("sin_cos_taylor_approx verification clean");
		else
			$display("sin_cos_taylor_approx verification failed");
		$finish;
	end

endmodule
